>>> sv/mte_pkg.sv
// Shared types and constants for the MIDI track event encoder.
package mte_pkg;

  // Input kind, carried in tuser
  typedef enum logic [1:0] {
    ACT_DELAY = 2'd0,
    ACT_CHAN  = 2'd1,
    ACT_META  = 2'd2,
    ACT_RAW   = 2'd3
  } action_e;

  localparam int unsigned SlotCnt    = 7;
  localparam int unsigned DelayW     = 28;
  localparam logic [DelayW-1:0] DelayMax = 28'hFFF_FFFF;
  localparam logic [7:0] VlqCont     = 8'h80;
  localparam logic [7:0] MetaPrefix  = 8'hFF;

  // Byte slots in emission order:
  // 0..3 delay groups (high to low), 4 status/0xFF/raw, 5 first data/type, 6 second data/length
  localparam int unsigned SlotD3   = 0;
  localparam int unsigned SlotD2   = 1;
  localparam int unsigned SlotD1   = 2;
  localparam int unsigned SlotD0   = 3;
  localparam int unsigned SlotHead = 4;
  localparam int unsigned SlotArgA = 5;
  localparam int unsigned SlotArgB = 6;

  // One encoded event: candidate bytes plus mask of those that go out
  typedef struct packed {
    logic [SlotCnt-1:0][7:0] bytes;
    logic [SlotCnt-1:0]      mask;
  } desc_t;

endpackage

>>> sv/mte_front.sv
// Front end: accepts events, keeps delay and running status, builds byte descriptors.
module mte_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [79:0]       fields_i,
  output logic              push_o,
  output mte_pkg::desc_t    desc_o,
  input  logic              full_i
);
  import mte_pkg::*;

  logic [DelayW-1:0] pend_q, pend_d;
  logic [7:0]        status_q, status_d;

  logic [DelayW-1:0] delay_amount;
  logic [7:0]        status_byte;
  logic [1:0]        data_count;
  logic [6:0]        data_first, data_second;
  logic [7:0]        meta_type, meta_length, raw_byte;
  logic [DelayW:0]   sum;
  logic              accept;
  action_e           act;

  assign delay_amount = fields_i[27:0];
  assign status_byte  = fields_i[35:28];
  assign data_count   = fields_i[37:36];
  assign data_first   = fields_i[44:38];
  assign data_second  = fields_i[51:45];
  assign meta_type    = fields_i[59:52];
  assign meta_length  = fields_i[67:60];
  assign raw_byte     = fields_i[75:68];

  assign act        = action_e'(action_i);
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign sum        = {1'b0, pend_q} + {1'b0, delay_amount};

  // Build descriptor and next state
  always_comb begin
    desc_o   = '0;
    pend_d   = pend_q;
    status_d = status_q;
    push_o   = 1'b0;

    // Variable-length delay groups, most significant first
    desc_o.bytes[SlotD3] = VlqCont | {1'b0, pend_q[27:21]};
    desc_o.bytes[SlotD2] = VlqCont | {1'b0, pend_q[20:14]};
    desc_o.bytes[SlotD1] = VlqCont | {1'b0, pend_q[13:7]};
    desc_o.bytes[SlotD0] = {1'b0, pend_q[6:0]};

    case (act)
      ACT_DELAY: begin
        if (accept) begin
          pend_d = sum[DelayW] ? DelayMax : sum[DelayW-1:0];
        end
      end
      ACT_CHAN: begin
        desc_o.mask[SlotD3]     = |pend_q[27:21];
        desc_o.mask[SlotD2]     = |pend_q[27:14];
        desc_o.mask[SlotD1]     = |pend_q[27:7];
        desc_o.mask[SlotD0]     = 1'b1;
        desc_o.bytes[SlotHead]  = status_byte;
        desc_o.mask[SlotHead]   = (status_byte != status_q);
        desc_o.bytes[SlotArgA]  = {1'b0, data_first};
        desc_o.mask[SlotArgA]   = (data_count != 2'd0);
        desc_o.bytes[SlotArgB]  = {1'b0, data_second};
        desc_o.mask[SlotArgB]   = data_count[1];
        push_o = accept;
        if (accept) begin
          pend_d   = '0;
          status_d = status_byte;
        end
      end
      ACT_META: begin
        desc_o.mask[SlotD3]     = |pend_q[27:21];
        desc_o.mask[SlotD2]     = |pend_q[27:14];
        desc_o.mask[SlotD1]     = |pend_q[27:7];
        desc_o.mask[SlotD0]     = 1'b1;
        desc_o.bytes[SlotHead]  = MetaPrefix;
        desc_o.mask[SlotHead]   = 1'b1;
        desc_o.bytes[SlotArgA]  = meta_type;
        desc_o.mask[SlotArgA]   = 1'b1;
        desc_o.bytes[SlotArgB]  = meta_length;
        desc_o.mask[SlotArgB]   = 1'b1;
        push_o = accept;
        if (accept) begin
          pend_d = '0;
        end
      end
      ACT_RAW: begin
        desc_o.bytes[SlotHead] = raw_byte;
        desc_o.mask[SlotHead]  = 1'b1;
        push_o = accept;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  // Delay accumulator and running status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      status_q <= '0;
    end else begin
      pend_q   <= pend_d;
      status_q <= status_d;
    end
  end

endmodule

>>> sv/mte_queue.sv
// Small descriptor queue between the front end and the byte serializer.
module mte_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mte_pkg::desc_t push_data_i,
  output logic           full_o,
  output logic           pop_valid_o,
  output mte_pkg::desc_t pop_data_o,
  input  logic           pop_i
);
  import mte_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/mte_back.sv
// Back end: walks a descriptor's byte mask and sends one byte per cycle while the receiver is ready.
module mte_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  mte_pkg::desc_t q_data_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);
  import mte_pkg::*;

  logic [SlotCnt-1:0][7:0] bytes_q, bytes_d;
  logic [SlotCnt-1:0]      rem_q, rem_d, sel, rem_after;
  logic                    vld_q, vld_d, last_q, last_d;
  logic [7:0]              byte_q, byte_d, pick;
  logic                    active, can_load, emit, take;

  assign active    = (rem_q != '0);
  assign can_load  = !vld_q || out_ready_i;
  assign emit      = active && can_load;
  assign sel       = rem_q & (~rem_q + 1'b1);
  assign rem_after = rem_q & ~sel;
  assign take      = q_valid_i && (!active || (emit && (rem_after == '0)));
  assign q_pop_o   = take;

  // Select the byte of the lowest pending slot
  always_comb begin
    pick = '0;
    for (int i = 0; i < SlotCnt; i++) begin
      pick = pick | (bytes_q[i] & {8{sel[i]}});
    end
  end

  // Next descriptor and output register
  always_comb begin
    bytes_d = bytes_q;
    rem_d   = rem_q;
    vld_d   = vld_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (can_load) begin
      vld_d = active;
    end
    if (emit) begin
      byte_d = pick;
      last_d = (rem_after == '0);
      rem_d  = rem_after;
    end
    if (take) begin
      bytes_d = q_data_i.bytes;
      rem_d   = q_data_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      vld_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    byte_q  <= byte_d;
    last_q  <= last_d;
  end

  assign out_valid_o = vld_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

>>> sv/midi_track_event_encoder_unit.sv
// Top level of the MIDI track event encoder (running status, variable-length delays).
//
// Input stream: one word per event; tuser carries the event kind (add delay, channel
// event, meta header, raw byte), tdata the event fields. Output stream: one encoded
// track byte per word, tlast marking the final byte caused by an event.
// A delay word only adds to the pending delay (saturating at 2^28-1) and produces no
// output. Channel and meta events first send the pending delay as 1..4 VLQ bytes;
// a channel status byte is sent only when it differs from the running status.
// Throughput: the input takes one word per cycle while the descriptor queue has room;
// the output sends one byte per cycle while the receiver is ready; an event has 1 to 7
// bytes. Bytes pass the queue, the back end's descriptor register and the output
// register. The queue (QUEUE_DEPTH events) and the output register let the input
// keep flowing while the receiver stalls; when the queue fills, s_axis_tready_o drops.
// Reset clears the pending delay, the running status (to zero) and all queued events.
module midi_track_event_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [27:0] delay_amount, [35:28] status_byte, [37:36] data_count, [44:38] data_first,
  // [51:45] data_second, [59:52] meta_type, [67:60] meta_length, [75:68] raw_byte,
  // [79:76] zero
  input  logic [79:0] s_axis_tdata_i,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] out_byte
  output logic [7:0]  m_axis_tdata_o,
  // last_of_run
  output logic        m_axis_tlast_o
);
  import mte_pkg::*;

  desc_t fr_desc, q_desc;
  logic  fr_push, q_full, q_valid, q_pop;

  mte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .action_i   (s_axis_tuser_i),
    .fields_i   (s_axis_tdata_i),
    .push_o     (fr_push),
    .desc_o     (fr_desc),
    .full_i     (q_full)
  );

  mte_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fr_push),
    .push_data_i (fr_desc),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_desc),
    .pop_i       (q_pop)
  );

  mte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_desc),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

>>> test/midi_track_event_encoder_unit_tb.sv
// Self-checking testbench for the MIDI track event encoder: directed table, then random events.
module midi_track_event_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mte_pkg::*;

  localparam time CLK_HALF    = 4ns;
  localparam int  RST_CYCLES  = 12;
  localparam int  DRAIN_WAIT  = 16;          // extra wait after the expected bytes have drained
  localparam int  RAND_EVENTS = 296;
  localparam int  DIR_ROWS    = 25;
  localparam int  TYPED_NONE  = -1;          // row checked by the predictor only
  localparam logic [27:0] DELAY_SAT = 28'hFFF_FFFF;

  // One directed or random event, with optional hand-typed byte sequence (first byte in MSBs)
  typedef struct {
    action_e     act;
    logic [79:0] fields;
    int          n_typed;
    logic [55:0] typed_seq;
  } stim_row_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } track_byte_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_axis_tready_o;
  logic [79:0] s_tdata = '0;
  action_e     s_tuser = ACT_DELAY;
  logic        m_axis_tvalid_o;
  logic        m_tready = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;

  // Typed expectation travels alongside the word it belongs to
  int          pin_n = TYPED_NONE;
  logic [55:0] pin_seq = '0;

  int unsigned src_idle_pct = 38;
  int unsigned snk_idle_pct = 48;
  int unsigned mismatch_cnt = 0;

  // Predictor state
  logic [27:0] pend_ticks = '0;
  logic [7:0]  run_status = '0;
  track_byte_t track_bytes_q[$];

  stim_row_t   dir_tbl[DIR_ROWS];

  midi_track_event_encoder_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_HALF);
    clk_i = 1'b1;
    #(CLK_HALF);
  end

  // tdata layout, lowest bits first
  function automatic logic [79:0] pack_fields(input logic [27:0] amt, input logic [7:0] st,
                                              input logic [1:0] cnt, input logic [6:0] d1,
                                              input logic [6:0] d2, input logic [7:0] mt,
                                              input logic [7:0] ml, input logic [7:0] raw);
    return {4'h0, raw, ml, mt, d2, d1, cnt, st, amt};
  endfunction

  function automatic stim_row_t ev_row(input action_e act, input logic [27:0] amt,
                                       input logic [7:0] st, input logic [1:0] cnt,
                                       input logic [6:0] d1, input logic [6:0] d2,
                                       input logic [7:0] mt, input logic [7:0] ml,
                                       input logic [7:0] raw, input int n_typed,
                                       input logic [55:0] seq);
    stim_row_t r;
    r.act       = act;
    r.fields    = pack_fields(amt, st, cnt, d1, d2, mt, ml, raw);
    r.n_typed   = n_typed;
    r.typed_seq = seq;
    return r;
  endfunction

  // Encoder model: updates pending delay / running status, returns the bytes of one event
  task automatic encode_event(input action_e act, input logic [79:0] f,
                              output int unsigned n, output logic [55:0] seq);
    logic [28:0] sum;
    logic [27:0] t;
    logic [7:0]  st;
    logic [7:0]  ob[$];
    ob = {};
    case (act)
      ACT_DELAY: begin
        sum = {1'b0, pend_ticks} + {1'b0, f[27:0]};
        pend_ticks = (sum > {1'b0, DELAY_SAT}) ? DELAY_SAT : sum[27:0];
      end
      ACT_CHAN, ACT_META: begin
        // delay as VLQ, most significant group first
        t = pend_ticks;
        pend_ticks = '0;
        if (t[27:21] != 0) ob.insert(ob.size(), {1'b1, t[27:21]});
        if (t[27:14] != 0) ob.insert(ob.size(), {1'b1, t[20:14]});
        if (t[27:7] != 0) ob.insert(ob.size(), {1'b1, t[13:7]});
        ob.insert(ob.size(), {1'b0, t[6:0]});
        if (act == ACT_CHAN) begin
          st = f[35:28];
          if (st != run_status) begin
            run_status = st;
            ob.insert(ob.size(), st);
          end
          if (f[37:36] >= 2'd1) ob.insert(ob.size(), {1'b0, f[44:38]});
          if (f[37:36] >= 2'd2) ob.insert(ob.size(), {1'b0, f[51:45]});
        end else begin
          ob.insert(ob.size(), MetaPrefix);
          ob.insert(ob.size(), f[59:52]);
          ob.insert(ob.size(), f[67:60]);
        end
      end
      default: begin
        ob.insert(ob.size(), f[75:68]);
      end
    endcase
    n = ob.size();
    seq = '0;
    for (int k = 0; k < ob.size(); k++) seq[55-8*k -: 8] = ob[k];
  endtask

  // Present one word, with random idle cycles in front, and wait until it is taken
  task automatic send_event(input stim_row_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= r.fields;
    s_tuser  <= r.act;
    pin_n    <= r.n_typed;
    pin_seq  <= r.typed_seq;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Receiver back-pressure
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Input words feed the predictor, output words are checked against it
  always @(posedge clk_i) begin : track_check
    int unsigned n;
    logic [55:0] seq;
    track_byte_t exp_b;
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) begin
        encode_event(s_tuser, s_tdata, n, seq);
        if (pin_n != TYPED_NONE) begin
          n   = pin_n;
          seq = pin_seq;
        end
        for (int k = 0; k < n; k++) begin
          exp_b.value = seq[55-8*k -: 8];
          exp_b.last  = (k == n - 1);
          track_bytes_q.insert(track_bytes_q.size(), exp_b);
        end
      end
      if (m_axis_tvalid_o && m_tready) begin
        if (track_bytes_q.size() == 0) begin
          $error("unexpected word: out_byte %02h, last_of_run %0b",
                 m_axis_tdata_o, m_axis_tlast_o);
          mismatch_cnt++;
        end else begin
          exp_b = track_bytes_q.pop_front();
          if (m_axis_tdata_o !== exp_b.value) begin
            $error("out_byte mismatch: expected %02h, actual %02h",
                   exp_b.value, m_axis_tdata_o);
            mismatch_cnt++;
          end
          if (m_axis_tlast_o !== exp_b.last) begin
            $error("last_of_run mismatch: expected %0b, actual %0b",
                   exp_b.last, m_axis_tlast_o);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    stim_row_t   r;
    logic [27:0] amt;
    logic [7:0]  st;
    logic [31:0] rnd;
    int unsigned sel;

    // Directed events; typed sequences where the bytes are obvious
    dir_tbl[0]  = ev_row(ACT_CHAN, 0, 8'h90, 2, 7'h3C, 7'h7F, 0, 0, 0,
                         4, 56'h00903C7F000000);
    // same status: running status drops the status byte
    dir_tbl[1]  = ev_row(ACT_CHAN, 0, 8'h90, 2, 7'h00, 7'h00, 0, 0, 0,
                         3, 56'h00000000000000);
    dir_tbl[2]  = ev_row(ACT_RAW, 0, 0, 0, 0, 0, 0, 0, 8'hFF, 1, 56'hFF000000000000);
    dir_tbl[3]  = ev_row(ACT_RAW, 0, 0, 0, 0, 0, 0, 0, 8'h00, 1, 56'h00000000000000);
    dir_tbl[4]  = ev_row(ACT_DELAY, 28'h7F, 0, 0, 0, 0, 0, 0, 0, 0, '0);
    dir_tbl[5]  = ev_row(ACT_CHAN, 0, 8'h90, 1, 7'h7F, 7'h55, 0, 0, 0,
                         2, 56'h7F7F0000000000);
    // two-group delay ahead of a meta header
    dir_tbl[6]  = ev_row(ACT_DELAY, 28'h80, 0, 0, 0, 0, 0, 0, 0, 0, '0);
    dir_tbl[7]  = ev_row(ACT_META, 0, 0, 0, 0, 0, 8'h2F, 8'h00, 0,
                         5, 56'h8100FF2F000000);
    // accumulator saturates at full scale
    dir_tbl[8]  = ev_row(ACT_DELAY, DELAY_SAT, 0, 0, 0, 0, 0, 0, 0, 0, '0);
    dir_tbl[9]  = ev_row(ACT_DELAY, 28'h1, 0, 0, 0, 0, 0, 0, 0, 0, '0);
    dir_tbl[10] = ev_row(ACT_CHAN, 0, 8'h80, 0, 0, 0, 0, 0, 0, 5, 56'hFFFFFF7F800000);
    dir_tbl[11] = ev_row(ACT_DELAY, 28'h3FFF, 0, 0, 0, 0, 0, 0, 0, 0, '0);
    dir_tbl[12] = ev_row(ACT_META, 0, 0, 0, 0, 0, 8'h51, 8'h03, 0,
                         5, 56'hFF7FFF51030000);
    // status without its high bit, and a data count of three
    dir_tbl[13] = ev_row(ACT_DELAY, 28'h4000, 0, 0, 0, 0, 0, 0, 0, 0, '0);
    dir_tbl[14] = ev_row(ACT_CHAN, 0, 8'h00, 3, 7'h12, 7'h34, 0, 0, 0,
                         6, 56'h81800000123400);
    dir_tbl[15] = ev_row(ACT_CHAN, 0, 8'h00, 0, 0, 0, 0, 0, 0, 1, 56'h00000000000000);
    // raw byte leaves the pending delay for the next event: four groups plus three bytes
    dir_tbl[16] = ev_row(ACT_DELAY, 28'h200000, 0, 0, 0, 0, 0, 0, 0, 0, '0);
    dir_tbl[17] = ev_row(ACT_RAW, 0, 0, 0, 0, 0, 0, 0, 8'h5A, 1, 56'h5A000000000000);
    dir_tbl[18] = ev_row(ACT_CHAN, 0, 8'hFF, 2, 7'h7F, 7'h7F, 0, 0, 0,
                         7, 56'h81808000FF7F7F);
    dir_tbl[19] = ev_row(ACT_META, 0, 0, 0, 0, 0, 8'hFF, 8'hFF, 0,
                         4, 56'h00FFFFFF000000);
    // meta header keeps running status
    dir_tbl[20] = ev_row(ACT_CHAN, 0, 8'hFF, 1, 7'h01, 7'h00, 0, 0, 0,
                         2, 56'h00010000000000);
    dir_tbl[21] = ev_row(ACT_DELAY, 28'h1234567, 0, 0, 0, 0, 0, 0, 0, TYPED_NONE, '0);
    dir_tbl[22] = ev_row(ACT_DELAY, 28'h0, 0, 0, 0, 0, 0, 0, 0, TYPED_NONE, '0);
    dir_tbl[23] = ev_row(ACT_CHAN, 0, 8'hC5, 2, 7'h55, 7'h2A, 0, 0, 0, TYPED_NONE, '0);
    dir_tbl[24] = ev_row(ACT_META, 28'h5, 0, 0, 0, 0, 8'h03, 8'h07, 0, TYPED_NONE, '0);

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) send_event(dir_tbl[i]);

    // Random events, idling swapped after a third, then none
    for (int i = 0; i < RAND_EVENTS; i++) begin
      if (i == RAND_EVENTS / 3) begin
        src_idle_pct = 48;
        snk_idle_pct = 38;
      end else if (i == 2 * RAND_EVENTS / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end

      // delays cluster around the VLQ group boundaries and full scale
      case ($urandom_range(0, 7))
        0, 1, 2: amt = 28'($urandom_range(0, 127));
        3:       amt = 28'((32'd1 << (7 * $urandom_range(1, 3))) - $urandom_range(0, 1));
        4:       amt = 28'($urandom_range(0, 2**21));
        5: begin
          rnd = $urandom();
          amt = rnd[27:0];
        end
        6:       amt = DELAY_SAT - 28'($urandom_range(0, 3));
        default: amt = 28'($urandom_range(0, 16383));
      endcase

      // a handful of statuses so running status hits often
      if ($urandom_range(0, 3) != 0)
        st = 8'(32'h80 | ($urandom_range(0, 2) << 4) | $urandom_range(0, 1));
      else
        st = 8'($urandom_range(0, 255));

      sel = $urandom_range(0, 99);
      r = ev_row((sel < 30) ? ACT_DELAY : (sel < 65) ? ACT_CHAN : (sel < 80) ? ACT_META
                 : ACT_RAW,
                 amt, st, 2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), TYPED_NONE, '0);
      send_event(r);
    end

    s_tvalid <= 1'b0;
    while (track_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
